// ===== src/kvts_pkg.sv =====
// Shared types and constants for the keyframe vector track sampler.
`default_nettype none
package kvts_pkg;
	localparam int MaxKeysDefault = 64;
	localparam int CountW = 7;
	localparam int TimeW = 24;
	localparam int ValW = 32;
	localparam int FracW = 16;
	localparam int SegW = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_key;
		logic rd_first;
		logic rd_last;
		logic rd_seg;
		logic rd_next;
		logic lat_first;
		logic lat_last;
		logic lat_cur;
		logic lat_next;
		logic clamp_t;
		logic step_up;
		logic step_dn;
		logic div_start;
		logic rd_lo;
		logic rd_hi;
		logic lat_lo;
		logic lat_hi;
		logic mul_start;
		logic emit;
		logic emit_single;
		logic set_before;
	} kvts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic single;
		logic before_first;
		logic t_ge_cur;
		logic can_up;
		logic want_up;
		logic can_dn;
		logic want_dn;
		logic div_done;
		logic mul_done;
	} kvts_sts_t;
endpackage
`default_nettype wire

// ===== src/kvts_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module kvts_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write or read one entry a cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== src/kvts_ctrl.sv =====
// Controller state machine of the track sampler.
`default_nettype none
module kvts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              mode,
	output logic                   busy,
	output kvts_pkg::kvts_cmd_t    cmd,
	input  wire kvts_pkg::kvts_sts_t sts
);
	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_RDFL   = 14'b00000000000010,
		S_RDSEG  = 14'b00000000000100,
		S_LATFL  = 14'b00000000001000,
		S_CLAMP  = 14'b00000000010000,
		S_LATCUR = 14'b00000000100000,
		S_DECIDE = 14'b00000001000000,
		S_RDNX   = 14'b00000010000000,
		S_CHECK  = 14'b00000100000000,
		S_DIV    = 14'b00001000000000,
		S_RDV    = 14'b00010000000000,
		S_LATV   = 14'b00100000000000,
		S_MUL    = 14'b01000000000000,
		S_SINGLE = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic up_q, up_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		up_d = up_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!mode) begin
						cmd.load_key = 1'b1;
					end else begin
						cmd.rd_first = 1'b1;
						state_d = S_RDFL;
					end
				end
			end
			S_RDFL: begin
				cmd.lat_first = 1'b1;
				cmd.rd_last = 1'b1;
				state_d = S_RDSEG;
			end
			S_RDSEG: begin
				cmd.lat_last = 1'b1;
				cmd.rd_seg = 1'b1;
				state_d = S_LATFL;
			end
			S_LATFL: begin
				if (sts.single) begin
					cmd.rd_lo = 1'b1;
					state_d = S_SINGLE;
				end else begin
					cmd.clamp_t = 1'b1;
					state_d = S_CLAMP;
				end
			end
			S_SINGLE: begin
				cmd.lat_lo = 1'b1;
				state_d = S_MUL;
				up_d = 1'b1;
			end
			S_CLAMP: begin
				cmd.lat_cur = 1'b1;
				state_d = S_LATCUR;
			end
			S_LATCUR: begin
				if (sts.before_first) begin
					cmd.set_before = 1'b1;
					cmd.rd_lo = 1'b1;
					state_d = S_RDV;
				end else begin
					up_d = sts.t_ge_cur;
					cmd.rd_next = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				// The key time read last cycle arrives; latch it.
				cmd.lat_next = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (up_q && sts.can_up && sts.want_up) begin
					cmd.step_up = 1'b1;
					state_d = S_RDNX;
				end else if (!up_q && sts.can_dn && sts.want_dn) begin
					cmd.step_dn = 1'b1;
					state_d = S_RDNX;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end
			end
			S_RDNX: begin
				// An up step needs the new next key, a down step the new current key.
				if (up_q) begin
					cmd.rd_next = 1'b1;
				end else begin
					cmd.rd_seg = 1'b1;
				end
				state_d = S_DECIDE;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.rd_lo = 1'b1;
					state_d = S_RDV;
				end
			end
			S_RDV: begin
				cmd.lat_lo = 1'b1;
				cmd.rd_hi = 1'b1;
				state_d = S_LATV;
			end
			S_LATV: begin
				cmd.lat_hi = 1'b1;
				cmd.mul_start = 1'b1;
				up_d = 1'b0;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (up_q) begin
					cmd.emit = 1'b1;
					cmd.emit_single = 1'b1;
					state_d = S_IDLE;
				end else if (sts.mul_done) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			up_q <= 1'b0;
		end else begin
			state_q <= state_d;
			up_q <= up_d;
		end
	end
endmodule
`default_nettype wire

// ===== src/kvts_dp.sv =====
// Datapath of the track sampler: key memories, search, divider and lerp.
`default_nettype none
module kvts_dp #(
	parameter int MaxKeys = kvts_pkg::MaxKeysDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire kvts_pkg::kvts_cmd_t          cmd,
	output kvts_pkg::kvts_sts_t               sts,
	input  wire logic [kvts_pkg::CountW-1:0]  key_count,
	input  wire logic [5:0]                   key_index,
	input  wire logic [kvts_pkg::TimeW-1:0]   time_value,
	input  wire logic [kvts_pkg::ValW-1:0]    value_x,
	input  wire logic [kvts_pkg::ValW-1:0]    value_y,
	input  wire logic [kvts_pkg::ValW-1:0]    value_z,
	output logic                              done,
	output logic [kvts_pkg::ValW-1:0]         out_x,
	output logic [kvts_pkg::ValW-1:0]         out_y,
	output logic [kvts_pkg::ValW-1:0]         out_z,
	output logic [kvts_pkg::SegW-1:0]         segment,
	output logic                              clamped
);
	localparam int AW = $clog2(MaxKeys);
	localparam int TW = kvts_pkg::TimeW;
	localparam int VW = kvts_pkg::ValW;
	localparam int FW = kvts_pkg::FracW;
	localparam int IW = AW + 1;

	logic [IW-1:0] n_eff, nm2;
	logic [AW-1:0] ram_addr, idx_q, addr_q;
	logic [TW-1:0] t_q, first_q, last_q, cur_q, nxt_q, rd_t;
	logic [VW-1:0] rd_x, rd_y, rd_z;
	logic [VW-1:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
	logic clamped_q;
	logic [FW-1:0] f_q;

	// Effective key count.
	always_comb begin
		if (key_count == '0) n_eff = IW'(1);
		else if (32'(key_count) > 32'(MaxKeys)) n_eff = IW'(MaxKeys);
		else n_eff = IW'(key_count);
		nm2 = n_eff - IW'(2);
	end

	// Memory address select; key 0 is read for a single key or a time before the first key.
	always_comb begin
		ram_addr = addr_q;
		if (cmd.load_key) ram_addr = AW'(key_index);
		else if (cmd.rd_first) ram_addr = '0;
		else if (cmd.rd_last) ram_addr = AW'(n_eff - IW'(1));
		else if (cmd.rd_seg) ram_addr = idx_q;
		else if (cmd.rd_next) ram_addr = idx_q + AW'(1);
		else if (cmd.rd_lo) ram_addr = (cmd.set_before || n_eff == IW'(1)) ? '0 : idx_q;
		else if (cmd.rd_hi) ram_addr = idx_q + AW'(1);
	end

	logic key_we;
	assign key_we = cmd.load_key && (32'(key_index) < 32'(MaxKeys));

	kvts_ram #(.Width(TW), .Depth(MaxKeys)) u_time (
		.clk(clk), .we(key_we), .addr(ram_addr), .wdata(time_value), .rdata(rd_t));
	kvts_ram #(.Width(VW), .Depth(MaxKeys)) u_x (
		.clk(clk), .we(key_we), .addr(ram_addr), .wdata(value_x), .rdata(rd_x));
	kvts_ram #(.Width(VW), .Depth(MaxKeys)) u_y (
		.clk(clk), .we(key_we), .addr(ram_addr), .wdata(value_y), .rdata(rd_y));
	kvts_ram #(.Width(VW), .Depth(MaxKeys)) u_z (
		.clk(clk), .we(key_we), .addr(ram_addr), .wdata(value_z), .rdata(rd_z));

	// Cached segment index, also used as the search index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.rd_first) begin
			if ({1'b0, idx_q} > nm2 && n_eff > IW'(1)) idx_q <= AW'(nm2);
		end else if (cmd.set_before) begin
			idx_q <= '0;
		end else if (cmd.step_up) begin
			idx_q <= idx_q + AW'(1);
		end else if (cmd.step_dn) begin
			idx_q <= idx_q - AW'(1);
		end else if (cmd.emit_single) begin
			idx_q <= idx_q;
		end
	end

	// Marks that the next latched key time belongs to the current key after a down step.
	logic dn_pending_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dn_pending_q <= 1'b0;
		else if (cmd.step_dn) dn_pending_q <= 1'b1;
		else if (cmd.lat_next) dn_pending_q <= 1'b0;
	end

	// Key times of the segment under test and the latched key values.
	// An up step moves the next key into the current one and reads the new next key;
	// a down step moves the current key into the next one and reads the new current key.
	always_ff @(posedge clk) begin
		addr_q <= ram_addr;
		if (cmd.rd_first) t_q <= time_value;
		if (cmd.lat_first) first_q <= rd_t;
		if (cmd.lat_last) last_q <= rd_t;
		if (cmd.lat_cur) cur_q <= rd_t;
		if (cmd.lat_next) begin
			if (dn_pending_q) cur_q <= rd_t;
			else nxt_q <= rd_t;
		end
		if (cmd.rd_first) clamped_q <= 1'b0;
		if (cmd.clamp_t && t_q > last_q) begin
			t_q <= (last_q != '0) ? last_q - TW'(1) : '0;
			clamped_q <= 1'b1;
		end
		if (cmd.set_before) clamped_q <= 1'b1;
		if (cmd.lat_lo) begin
			lo_x_q <= rd_x; lo_y_q <= rd_y; lo_z_q <= rd_z;
		end
		if (cmd.lat_hi) begin
			hi_x_q <= rd_x; hi_y_q <= rd_y; hi_z_q <= rd_z;
		end
		if (cmd.step_up) cur_q <= nxt_q;
		if (cmd.step_dn) nxt_q <= cur_q;
	end

	logic [TW-1:0] cur_eff;
	assign cur_eff = cur_q;

	// Serial restoring divider for the Q0.16 factor.
	logic [TW-1:0] den_q;
	logic [TW:0] rem_q, rem_sh;
	logic [4:0] cnt_q;
	logic div_run_q;
	assign rem_sh = {rem_q[TW-1:0], 1'b0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			if (t_q < cur_q || nxt_q <= cur_q) begin
				f_q <= '0;
				div_run_q <= 1'b0;
			end else if (t_q - cur_q >= nxt_q - cur_q) begin
				f_q <= '1;
				div_run_q <= 1'b0;
			end else begin
				den_q <= nxt_q - cur_q;
				rem_q <= {1'b0, t_q - cur_q};
				div_run_q <= 1'b1;
				cnt_q <= '0;
			end
		end else if (cmd.set_before) begin
			f_q <= '0;
		end else if (cmd.lat_lo && !div_run_q) begin
			f_q <= f_q;
		end else if (div_run_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				f_q <= {f_q[FW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				f_q <= {f_q[FW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(FW - 1)) div_run_q <= 1'b0;
		end
	end

	// Lerp: one signed 33x17 multiply per component, taken the cycle after
	// both end keys are latched and registered.
	logic [VW:0] dx, dy, dz;
	logic signed [VW+FW+1:0] px_s1, py_s1, pz_s1;
	logic mul_q, mul_dly_q;
	assign dx = {hi_x_q[VW-1], hi_x_q} - {lo_x_q[VW-1], lo_x_q};
	assign dy = {hi_y_q[VW-1], hi_y_q} - {lo_y_q[VW-1], lo_y_q};
	assign dz = {hi_z_q[VW-1], hi_z_q} - {lo_z_q[VW-1], lo_z_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			mul_dly_q <= 1'b0;
		end else begin
			mul_q <= cmd.mul_start;
			mul_dly_q <= mul_q;
		end
	end
	always_ff @(posedge clk) begin
		if (mul_q) begin
			px_s1 <= (VW+FW+2)'($signed(dx) * $signed({1'b0, f_q}));
			py_s1 <= (VW+FW+2)'($signed(dy) * $signed({1'b0, f_q}));
			pz_s1 <= (VW+FW+2)'($signed(dz) * $signed({1'b0, f_q}));
		end
	end

	// Search status.
	always_comb begin
		sts = '0;
		sts.single = (n_eff == IW'(1));
		sts.before_first = (t_q < first_q);
		sts.t_ge_cur = (t_q >= cur_eff);
		sts.can_up = ({1'b0, idx_q} < nm2);
		sts.want_up = (t_q >= nxt_q);
		sts.can_dn = (idx_q != '0);
		sts.want_dn = (t_q < cur_eff);
		sts.div_done = !div_run_q;
		sts.mul_done = mul_dly_q;
	end

	// Arithmetic shift floors, matching the rounding toward minus infinity.
	logic signed [VW+FW+1:0] qx, qy, qz;
	assign qx = px_s1 >>> FW;
	assign qy = py_s1 >>> FW;
	assign qz = pz_s1 >>> FW;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.emit;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.emit_single) begin
				out_x <= lo_x_q; out_y <= lo_y_q; out_z <= lo_z_q;
				segment <= '0;
				clamped <= 1'b0;
			end else begin
				out_x <= lo_x_q + qx[VW-1:0];
				out_y <= lo_y_q + qy[VW-1:0];
				out_z <= lo_z_q + qz[VW-1:0];
				segment <= kvts_pkg::SegW'(idx_q);
				clamped <= clamped_q;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/keyframe_vector_track_sampler.sv =====
// Top level of the keyframe vector track sampler.
// Load commands (mode 0) complete at the accepting edge and never raise busy.
// A sample command keeps busy high through the segment search, which steps
// one key at a time, and through the bit-serial factor divider when the
// segment is not degenerate; a single-key track and a time before the first
// key skip both. The result appears for one cycle with done high, in the
// cycle busy falls, and cannot be held off by the receiver.
`default_nettype none
module keyframe_vector_track_sampler #(
	parameter int MaxKeys = kvts_pkg::MaxKeysDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [5:0]  key_index,
	input  wire logic [23:0] time_value,
	input  wire logic [31:0] value_x,
	input  wire logic [31:0] value_y,
	input  wire logic [31:0] value_z,
	output logic             done,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic [31:0]      out_z,
	output logic [5:0]       segment,
	output logic             clamped,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [kvts_pkg::CountW-1:0] key_count_q;
	kvts_pkg::kvts_cmd_t cmd;
	kvts_pkg::kvts_sts_t sts;

	// Configuration register: key count at address 0.
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {25'd0, key_count_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_count_q <= 7'd1;
		else if (psel && penable && pwrite && paddr == 2'd0) key_count_q <= pwdata[6:0];
	end

	kvts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode),
		.busy(busy), .cmd(cmd), .sts(sts));

	kvts_dp #(.MaxKeys(MaxKeys)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.key_count(key_count_q), .key_index(key_index), .time_value(time_value),
		.value_x(value_x), .value_y(value_y), .value_z(value_z),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.segment(segment), .clamped(clamped));
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the keyframe vector track sampler.
`default_nettype none
module tb_top;
	localparam int NumKeys = 64;
	localparam logic [1:0] AddrKeyCount = 2'd0;

	// One command word and one sampled result word.
	typedef struct {
		logic        mode;
		logic [5:0]  idx;
		logic [23:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} track_cmd_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [5:0]  seg;
		logic        clamped;
	} sample_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = 1'b0;
	logic [5:0] key_index = '0;
	logic [23:0] time_value = '0;
	logic [31:0] value_x = '0;
	logic [31:0] value_y = '0;
	logic [31:0] value_z = '0;
	logic done;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic [5:0] segment;
	logic clamped;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	keyframe_vector_track_sampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.key_index(key_index), .time_value(time_value), .value_x(value_x),
		.value_y(value_y), .value_z(value_z), .done(done), .out_x(out_x),
		.out_y(out_y), .out_z(out_z), .segment(segment), .clamped(clamped),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the track.
	logic [23:0] trk_time [NumKeys];
	logic [31:0] trk_x [NumKeys];
	logic [31:0] trk_y [NumKeys];
	logic [31:0] trk_z [NumKeys];
	int unsigned trk_cache = 0;
	logic [6:0] trk_count = 7'd1;

	track_cmd_t cmd_q[$];
	sample_word_t sample_q[$];
	track_cmd_t cur_cmd;
	int idle_pct = 34;
	int err_count = 0;
	int sent = 0;

	function automatic logic [31:0] lerp_q16(input logic [31:0] a, input logic [31:0] b,
			input longint f);
		longint sa;
		longint d;
		sa = longint'($signed(a));
		d = longint'($signed(b)) - sa;
		return 32'(sa + ((d * f) >>> 16));
	endfunction

	// Segment search, factor and lerp for one sample time.
	function automatic sample_word_t sample_track(input logic [23:0] tin);
		sample_word_t r;
		int unsigned n, i, seg, last, t;
		longint f, num, dt;
		n = trk_count;
		if (n < 1) n = 1;
		if (n > NumKeys) n = NumKeys;
		t = tin;
		f = 0;
		r.clamped = 1'b0;
		if (n == 1) begin
			r.x = trk_x[0];
			r.y = trk_y[0];
			r.z = trk_z[0];
			r.seg = '0;
			return r;
		end
		last = trk_time[n - 1];
		if (t > last) begin
			t = (last != 0) ? last - 1 : 0;
			r.clamped = 1'b1;
		end
		if (t < trk_time[0]) begin
			seg = 0;
			r.clamped = 1'b1;
			trk_cache = 0;
		end else begin
			i = trk_cache;
			if (i > n - 2) i = n - 2;
			if (t >= trk_time[i]) begin
				while (i < n - 2 && t >= trk_time[i + 1]) i++;
			end else begin
				while (i > 0 && t < trk_time[i]) i--;
			end
			seg = i;
			trk_cache = i;
			if (!(t < trk_time[i] || trk_time[i + 1] <= trk_time[i])) begin
				num = t - trk_time[i];
				dt = trk_time[i + 1] - trk_time[i];
				f = (num >= dt) ? 64'hFFFF : (num << 16) / dt;
			end
		end
		r.x = lerp_q16(trk_x[seg], trk_x[seg + 1], f);
		r.y = lerp_q16(trk_y[seg], trk_y[seg + 1], f);
		r.z = lerp_q16(trk_z[seg], trk_z[seg + 1], f);
		r.seg = seg[5:0];
		return r;
	endfunction

	// Apply an accepted word to the shadow track.
	task automatic take_cmd(input track_cmd_t c);
		if (c.mode == 1'b0) begin
			trk_time[c.idx] = c.t;
			trk_x[c.idx] = c.x;
			trk_y[c.idx] = c.y;
			trk_z[c.idx] = c.z;
		end else begin
			sample_q.insert(sample_q.size(), sample_track(c.t));
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		err_count++;
	endtask

	// Driver: hands out queued words, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) take_cmd(cur_cmd);
			if (!start || !busy) begin
				if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					cur_cmd = cmd_q.pop_front();
					start <= 1'b1;
					mode <= cur_cmd.mode;
					key_index <= cur_cmd.idx;
					time_value <= cur_cmd.t;
					value_x <= cur_cmd.x;
					value_y <= cur_cmd.y;
					value_z <= cur_cmd.z;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sample_q.size() == 0) begin
				report("unexpected word", out_x, 32'd0);
			end else begin
				sample_word_t w;
				w = sample_q.pop_front();
				if (out_x !== w.x) report("out_x", out_x, w.x);
				if (out_y !== w.y) report("out_y", out_y, w.y);
				if (out_z !== w.z) report("out_z", out_z, w.z);
				if (segment !== w.seg) report("segment", 32'(segment), 32'(w.seg));
				if (clamped !== w.clamped) report("clamped", 32'(clamped), 32'(w.clamped));
			end
		end
	end

	task automatic push_load(input int idx, input logic [23:0] t);
		track_cmd_t c;
		c.mode = 1'b0;
		c.idx = idx[5:0];
		c.t = t;
		c.x = $urandom();
		c.y = $urandom();
		c.z = $urandom();
		cmd_q.insert(cmd_q.size(), c);
		sent++;
	endtask

	task automatic push_sample(input logic [23:0] t);
		track_cmd_t c;
		c.mode = 1'b1;
		c.idx = 6'($urandom());
		c.t = t;
		c.x = $urandom();
		c.y = $urandom();
		c.z = $urandom();
		cmd_q.insert(cmd_q.size(), c);
		sent++;
	endtask

	// Wait until everything has drained, then let a load-only tail settle.
	task automatic drain();
		@(negedge clk);
		while (cmd_q.size() > 0 || start || busy || sample_q.size() > 0) @(negedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_count(input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AddrKeyCount;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		trk_count = v[6:0];
	endtask

	// Stimulus: directed words, then random phases with varied key counts.
	initial begin
		int n, ph, kind, nsamp, base, lo, hi;
		logic [23:0] tk;
		logic [23:0] times [NumKeys];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// Fill every slot so no sample ever reads an unwritten key.
		for (int i = 0; i < NumKeys; i++) push_load(i, 24'(i * 100 + 50));
		cmd_q[0].x = 32'h8000_0000; cmd_q[0].y = 32'h7FFF_FFFF; cmd_q[0].z = 32'h0;
		cmd_q[1].x = 32'h7FFF_FFFF; cmd_q[1].y = 32'h8000_0000; cmd_q[1].z = 32'hFFFF_FFFF;
		cmd_q[63].t = 24'hFFFFFF;
		push_sample(24'd500);
		drain();
		write_count(32'd64);
		push_sample(24'd125);
		push_sample(24'd0);
		push_sample(24'hFFFFFF);
		push_sample(24'd60);
		push_sample(24'd6250);
		push_sample(24'd150);
		push_sample(24'd149);
		drain();
		write_count(32'd0);
		push_sample(24'd1234);
		drain();
		write_count(32'h7F);
		push_sample(24'hFFFFFE);
		push_sample(24'd77);
		drain();
		ph = 0;
		while (sent < 800) begin
			kind = $urandom_range(9);
			case ($urandom_range(9))
				0: n = 64;
				1: n = 2;
				2: n = $urandom_range(65, 127);
				3: n = $urandom_range(0, 1);
				default: n = $urandom_range(2, 16);
			endcase
			idle_pct = (ph == 3) ? 0 : 34;
			write_count(32'(n) | ($urandom() & 32'hFFFF_FF80));
			if (n < 1) n = 1;
			if (n > NumKeys) n = NumKeys;
			// Times: mostly ascending, sometimes all zero or scrambled.
			base = $urandom_range(0, 24'hFFFFFF - NumKeys * 5000);
			for (int i = 0; i < n; i++) begin
				if (kind == 0) tk = '0;
				else if (kind == 1) tk = 24'($urandom());
				else if (i == 0) tk = 24'(base);
				else case ($urandom_range(9))
					0: tk = times[i - 1];
					1, 2: tk = 24'(times[i - 1] + $urandom_range(1, 4));
					default: tk = 24'(times[i - 1] + $urandom_range(1, 5000));
				endcase
				times[i] = tk;
				push_load(i, tk);
			end
			lo = (times[0] > 3) ? times[0] - 3 : 0;
			hi = times[n - 1] + 3;
			if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
			nsamp = $urandom_range(30, 60);
			for (int s = 0; s < nsamp; s++) begin
				if ($urandom_range(4) == 0) push_sample(24'($urandom()));
				else push_sample(24'($urandom_range(lo, hi)));
				// Occasional stray load into a slot beyond the track.
				if (n < NumKeys && $urandom_range(19) == 0)
					push_load($urandom_range(n, NumKeys - 1), 24'($urandom()));
			end
			drain();
			ph++;
		end
		if (err_count == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
